@@ rtl/hidkr_pkg.sv @@
// Package for the HID boot keyboard report tracker.
// Shared constants, codes and types; no dependencies.
package hidkr_pkg;

  localparam int SLOT_COUNT    = 6;
  localparam int KEY_SLOTS_DEF = 6;
  localparam int USAGE_W       = 8;

  typedef logic [USAGE_W-1:0] usage_t;
  typedef logic [7:0]         mod_bits_t;

  // Modifier usages 0xE0..0xE7 share the top five bits
  localparam logic [4:0] MOD_PREFIX = 5'b11100;
  localparam usage_t     USAGE_NONE = '0;

  localparam logic ACT_KEY_EVENT   = 1'b0;
  localparam logic ACT_RELEASE_ALL = 1'b1;

  localparam logic KIND_REPORT      = 1'b0;
  localparam logic KIND_RELEASE_ALL = 1'b1;

  typedef struct packed {
    logic   action;
    usage_t key_code;
    logic   pressed;
  } key_item_t;

  typedef struct packed {
    logic emit;
    logic kind;
  } upd_ctl_t;

endpackage

@@ rtl/hidkr_if.sv @@
// Channel interfaces: key event items in, report items out.
// Depends on hidkr_pkg.
interface hidkr_key_if
  import hidkr_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   action;
  usage_t key_code;
  logic   pressed;

  modport source (output valid, action, key_code, pressed, input ready);
  modport sink (input valid, action, key_code, pressed, output ready);
endinterface

interface hidkr_report_if
  import hidkr_pkg::*;
();
  logic      valid;
  logic      ready;
  logic      report_kind;
  mod_bits_t modifier_bits;
  usage_t    slot_0;
  usage_t    slot_1;
  usage_t    slot_2;
  usage_t    slot_3;
  usage_t    slot_4;
  usage_t    slot_5;

  modport source (output valid, report_kind, modifier_bits,
                  slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, input ready);
  modport sink (input valid, report_kind, modifier_bits,
                slot_0, slot_1, slot_2, slot_3, slot_4, slot_5, output ready);
endinterface

@@ rtl/hidkr_in_reg.sv @@
// Input register for key event items.
// Depends on hidkr_pkg and hidkr_key_if.
module hidkr_in_reg
  import hidkr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hidkr_key_if.sink   in_key,
  input  logic        take,
  output logic        item_valid,
  output key_item_t   item
);

  logic      valid_r;
  logic      valid_nxt;
  key_item_t item_r;

  assign in_key.ready = !valid_r || take;
  assign valid_nxt    = in_key.valid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_key.valid && in_key.ready) begin
      item_r <= '{action: in_key.action, key_code: in_key.key_code,
                  pressed: in_key.pressed};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/hidkr_update.sv @@
// Next-state logic: modifier byte and key slots for one item.
// Depends on hidkr_pkg.
module hidkr_update
  import hidkr_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  key_item_t item,
  input  mod_bits_t mods,
  input  usage_t    keys [KEY_SLOTS],
  output mod_bits_t mods_nxt,
  output usage_t    keys_nxt [KEY_SLOTS],
  output upd_ctl_t  ctl
);

  logic      is_mod;
  mod_bits_t mod_bit;
  mod_bits_t mod_new;
  logic      any_match;
  logic      any_empty;
  logic      seen_match;
  logic      seen_empty;
  logic      code_zero;

  assign code_zero = (item.key_code == USAGE_NONE);
  assign is_mod    = (item.key_code[7:3] == MOD_PREFIX);
  assign mod_bit   = mod_bits_t'(1) << item.key_code[2:0];
  assign mod_new   = item.pressed ? (mods | mod_bit) : (mods & ~mod_bit);

  always_comb begin
    mods_nxt   = mods;
    keys_nxt   = keys;
    ctl        = '{emit: 1'b0, kind: KIND_REPORT};
    any_match  = 1'b0;
    any_empty  = 1'b0;
    seen_match = 1'b0;
    seen_empty = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      any_match = any_match | (keys[i] == item.key_code);
      any_empty = any_empty | (keys[i] == USAGE_NONE);
    end
    if (item.action == ACT_RELEASE_ALL) begin
      mods_nxt = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys_nxt[i] = USAGE_NONE;
      end
      ctl = '{emit: 1'b1, kind: KIND_RELEASE_ALL};
    end else if (code_zero) begin
      ctl.emit = 1'b0;
    end else if (is_mod) begin
      mods_nxt = mod_new;
      ctl.emit = (mod_new != mods);
    end else if (item.pressed) begin
      // slots are packed from the front, so the first empty one takes the key
      if (!any_match && any_empty) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (keys[i] == USAGE_NONE && !seen_empty) begin
            keys_nxt[i] = item.key_code;
          end
          seen_empty = seen_empty | (keys[i] == USAGE_NONE);
        end
        ctl.emit = 1'b1;
      end
    end else begin
      if (any_match) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          seen_match = seen_match | (keys[i] == item.key_code);
          if (seen_match) begin
            keys_nxt[i] = (i + 1 < KEY_SLOTS) ? keys[(i + 1) % KEY_SLOTS] : USAGE_NONE;
          end
        end
        ctl.emit = 1'b1;
      end
    end
  end

endmodule

@@ rtl/hid_keyboard_report_tracker_top.sv @@
// Top level of the HID boot keyboard report tracker.
// Depends on hidkr_pkg, hidkr_if, hidkr_in_reg and hidkr_update.
//
//   channel     dir  handshake    payload
//   in_key      in   valid/ready  action, key_code, pressed
//   out_report  out  valid/ready  report_kind, modifier_bits, slot_0..slot_5
//
// One item per cycle while out_report is not stalled. An accepted item is held in
// the input register, then applied to the state, gated only by room in the output
// register, which takes the report if the item emits one.
// Synchronous active-low reset empties both registers and clears all slots.
// A stalled result holds the pipe; the input register still takes one item.
module hid_keyboard_report_tracker_top
  import hidkr_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  hidkr_key_if.sink       in_key,
  hidkr_report_if.source  out_report
);

  logic      item_valid;
  key_item_t item;
  logic      fire;

  mod_bits_t mods_r;
  mod_bits_t mods_nxt;
  usage_t    keys_r   [KEY_SLOTS];
  usage_t    keys_nxt [KEY_SLOTS];
  upd_ctl_t  ctl;

  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      out_kind_r;
  mod_bits_t out_mods_r;
  usage_t    out_slots_r [SLOT_COUNT];
  usage_t    slot_src    [SLOT_COUNT];

  hidkr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (in_key),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  hidkr_update #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_update (
    .item     (item),
    .mods     (mods_r),
    .keys     (keys_r),
    .mods_nxt (mods_nxt),
    .keys_nxt (keys_nxt),
    .ctl      (ctl)
  );

  assign fire          = item_valid && (!out_valid_r || out_report.ready);
  assign out_valid_nxt = fire ? ctl.emit : (out_valid_r && !out_report.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys_r[i] <= USAGE_NONE;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        mods_r <= mods_nxt;
        keys_r <= keys_nxt;
      end
    end
  end

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
    if (g < KEY_SLOTS) begin : g_used
      assign slot_src[g] = keys_nxt[g];
    end else begin : g_unused
      assign slot_src[g] = USAGE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.emit) begin
      out_kind_r  <= ctl.kind;
      out_mods_r  <= mods_nxt;
      out_slots_r <= slot_src;
    end
  end

  assign out_report.valid         = out_valid_r;
  assign out_report.report_kind   = out_kind_r;
  assign out_report.modifier_bits = out_mods_r;
  assign out_report.slot_0        = out_slots_r[0];
  assign out_report.slot_1        = out_slots_r[1];
  assign out_report.slot_2        = out_slots_r[2];
  assign out_report.slot_3        = out_slots_r[3];
  assign out_report.slot_4        = out_slots_r[4];
  assign out_report.slot_5        = out_slots_r[5];

endmodule

@@ tb/hid_keyboard_report_tracker_top_test.sv @@
// Testbench for hid_keyboard_report_tracker_top: directed and random key items.
// Results are checked against an in-bench report tracker, with idles on both channels.
// Depends on hidkr_pkg, hidkr_if and the RTL top level.
module hid_keyboard_report_tracker_top_test;
  import hidkr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 525;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic                       kind;
    mod_bits_t                  mods;
    usage_t [SLOT_COUNT-1:0]    keys;
  } report_t;

  logic clk;
  logic rst_n;

  hidkr_key_if    key_ch();
  hidkr_report_if rpt_ch();

  hid_keyboard_report_tracker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_key     (key_ch),
    .out_report (rpt_ch)
  );

  key_item_t pending_keys[$];
  report_t   expected_reports[$];

  mod_bits_t mod_state;
  usage_t    held_slots[SLOT_COUNT];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int calm_left      = 0;
  bit calm           = 1'b0;
  int in_gap         = 0;
  int out_stall      = 0;

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic report_t snapshot(logic kind);
    report_t rep;
    rep.kind = kind;
    rep.mods = mod_state;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      rep.keys[i] = held_slots[i];
    end
    return rep;
  endfunction

  // Applies one accepted item to the tracked state and queues its report, if any.
  task automatic track_key(key_item_t it);
    int        n;
    mod_bits_t prev;
    n = KEY_SLOTS_DEF;
    if (it.action == ACT_RELEASE_ALL) begin
      mod_state = '0;
      for (int i = 0; i < SLOT_COUNT; i++) held_slots[i] = USAGE_NONE;
      expected_reports.push_back(snapshot(KIND_RELEASE_ALL));
      return;
    end
    if (it.key_code == USAGE_NONE) return;
    if (it.key_code[7:3] == MOD_PREFIX) begin
      prev = mod_state;
      mod_state[it.key_code[2:0]] = it.pressed;
      if (mod_state != prev) expected_reports.push_back(snapshot(KIND_REPORT));
      return;
    end
    if (it.pressed) begin
      for (int i = 0; i < n; i++) begin
        if (held_slots[i] == it.key_code) return;
        if (held_slots[i] == USAGE_NONE) begin
          held_slots[i] = it.key_code;
          expected_reports.push_back(snapshot(KIND_REPORT));
          return;
        end
      end
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (held_slots[i] == USAGE_NONE) return;
      if (held_slots[i] == it.key_code) begin
        for (int j = i; j + 1 < n; j++) held_slots[j] = held_slots[j + 1];
        held_slots[n - 1] = USAGE_NONE;
        expected_reports.push_back(snapshot(KIND_REPORT));
        return;
      end
    end
  endtask

  task automatic add_key(logic action, usage_t code, logic pressed);
    key_item_t it;
    it.action   = action;
    it.key_code = code;
    it.pressed  = pressed;
    pending_keys.push_back(it);
  endtask

  // Mostly presses and releases from a small pool so rollover and shifts are common.
  function automatic key_item_t random_key();
    key_item_t it;
    int        r;
    r = $urandom_range(0, 99);
    it.action   = (r < 3) ? ACT_RELEASE_ALL : ACT_KEY_EVENT;
    it.pressed  = ($urandom_range(0, 99) < 55);
    if (r < 3)       it.key_code = usage_t'($urandom_range(0, 255));
    else if (r < 22) it.key_code = {MOD_PREFIX, 3'($urandom_range(0, 7))};
    else if (r < 30) it.key_code = usage_t'($urandom_range(0, 255));
    else if (r < 32) it.key_code = USAGE_NONE;
    else             it.key_code = usage_t'(8'h04 + $urandom_range(0, 9));
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (calm_left == 0) begin
      calm      <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(20, 120);
    end else begin
      calm_left <= calm_left - 1;
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk) begin
    key_item_t nxt;
    key_item_t cur;
    if (!rst_n) begin
      key_ch.valid <= 1'b0;
      in_gap       <= 0;
    end else begin
      if (key_ch.valid && key_ch.ready) begin
        cur.action   = key_ch.action;
        cur.key_code = key_ch.key_code;
        cur.pressed  = key_ch.pressed;
        track_key(cur);
      end
      if (!key_ch.valid || key_ch.ready) begin
        if (in_gap != 0) begin
          key_ch.valid <= 1'b0;
          in_gap       <= in_gap - 1;
        end else if (pending_keys.size() != 0) begin
          nxt = pending_keys.pop_front();
          key_ch.valid    <= 1'b1;
          key_ch.action   <= nxt.action;
          key_ch.key_code <= nxt.key_code;
          key_ch.pressed  <= nxt.pressed;
          in_gap          <= calm ? 0 : idle_cycles();
        end else begin
          key_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor
  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (!rst_n) begin
      rpt_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (rpt_ch.valid && rpt_ch.ready) begin
        seen.kind    = rpt_ch.report_kind;
        seen.mods    = rpt_ch.modifier_bits;
        seen.keys[0] = rpt_ch.slot_0;
        seen.keys[1] = rpt_ch.slot_1;
        seen.keys[2] = rpt_ch.slot_2;
        seen.keys[3] = rpt_ch.slot_3;
        seen.keys[4] = rpt_ch.slot_4;
        seen.keys[5] = rpt_ch.slot_5;
        if (expected_reports.size() == 0) begin
          $error("unexpected report item: %h", seen);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (seen.kind !== want.kind) begin
            $error("report_kind: expected %0d, got %0d", want.kind, seen.kind);
            mismatch_count++;
          end
          if (seen.mods !== want.mods) begin
            $error("modifier_bits: expected %h, got %h", want.mods, seen.mods);
            mismatch_count++;
          end
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (seen.keys[i] !== want.keys[i]) begin
              $error("slot_%0d: expected %h, got %h", i, want.keys[i], seen.keys[i]);
              mismatch_count++;
            end
          end
        end
      end
      if (out_stall != 0) begin
        rpt_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else begin
        rpt_ch.ready <= 1'b1;
        if (!calm) out_stall <= idle_cycles();
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    key_ch.valid    = 1'b0;
    key_ch.action   = ACT_KEY_EVENT;
    key_ch.key_code = USAGE_NONE;
    key_ch.pressed  = 1'b0;
    rpt_ch.ready    = 1'b0;
    mod_state       = '0;
    for (int i = 0; i < SLOT_COUNT; i++) held_slots[i] = USAGE_NONE;

    // directed: zero code, modifier edges, fill to rollover, shifts, release-all
    add_key(ACT_KEY_EVENT, USAGE_NONE, 1'b1);
    add_key(ACT_KEY_EVENT, USAGE_NONE, 1'b0);
    add_key(ACT_KEY_EVENT, 8'hE0, 1'b1);
    add_key(ACT_KEY_EVENT, 8'hE0, 1'b1);
    add_key(ACT_KEY_EVENT, 8'hE7, 1'b1);
    add_key(ACT_KEY_EVENT, 8'hE7, 1'b0);
    add_key(ACT_KEY_EVENT, 8'hE7, 1'b0);
    for (int k = 0; k < 6; k++) add_key(ACT_KEY_EVENT, usage_t'(8'h04 + k), 1'b1);
    add_key(ACT_KEY_EVENT, 8'h0A, 1'b1);
    add_key(ACT_KEY_EVENT, 8'h04, 1'b1);
    add_key(ACT_KEY_EVENT, 8'h06, 1'b0);
    add_key(ACT_KEY_EVENT, 8'h99, 1'b0);
    add_key(ACT_KEY_EVENT, 8'hFF, 1'b1);
    add_key(ACT_KEY_EVENT, 8'h04, 1'b0);
    add_key(ACT_KEY_EVENT, 8'hFF, 1'b0);
    add_key(ACT_KEY_EVENT, 8'hE8, 1'b1);
    add_key(ACT_RELEASE_ALL, 8'hFF, 1'b1);
    add_key(ACT_KEY_EVENT, 8'h05, 1'b0);
    add_key(ACT_KEY_EVENT, 8'hDF, 1'b1);
    add_key(ACT_KEY_EVENT, 8'hE3, 1'b0);
    add_key(ACT_RELEASE_ALL, USAGE_NONE, 1'b0);
    for (int k = 0; k < RANDOM_ITEMS; k++) pending_keys.push_back(random_key());

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_keys.size() != 0 || key_ch.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
